[sv/vma_pkg.sv]
// ----------------------------------------------------------------------------
// vma_pkg
// Shared widths, command codes, step program and controller/datapath structs
// for the velocity moment accumulator.
// ----------------------------------------------------------------------------
package vma_pkg;

   localparam int IMPULSE_WIDTH   = 16;
   localparam int VALUE_WIDTH     = 32;
   localparam int ACC_WIDTH       = 64;
   localparam int OUT_WIDTH       = 48;
   localparam int CSR_WIDTH       = 32;
   localparam int CSR_INDEX_WIDTH = 1;
   localparam int WIDE_WIDTH      = 128;
   localparam int MULB_WIDTH      = 64;
   localparam int P2_WIDTH        = 2 * IMPULSE_WIDTH + 2;
   localparam int CNT_WIDTH       = $clog2(WIDE_WIDTH + 1);
   localparam int STEP_WIDTH      = 6;
   localparam int NUM_AXES        = 3;
   localparam int AXIS_WIDTH      = 2;

   localparam int PF_SHIFT   = 8;
   localparam int P2F_SHIFT  = 16;
   localparam int HEAT_SHIFT = 24;
   localparam int DENS_SHIFT = 16;
   localparam int TEMP_SHIFT = 32;
   localparam int FLUX_SHIFT = 15;

   localparam logic [CSR_WIDTH-1:0] CSR_RESET_VALUE = CSR_WIDTH'(65536);
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_PARTICLE_MASS = 1'b0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_CELL_VOLUME   = 1'b1;

   localparam logic [AXIS_WIDTH-1:0] AXIS_X = 2'd0;
   localparam logic [AXIS_WIDTH-1:0] AXIS_Y = 2'd1;
   localparam logic [AXIS_WIDTH-1:0] AXIS_Z = 2'd2;

   localparam logic KIND_MUL = 1'b0;
   localparam logic KIND_DIV = 1'b1;

   localparam logic [3:0] A_MAG     = 4'd0;
   localparam logic [3:0] A_P2      = 4'd1;
   localparam logic [3:0] A_TMP     = 4'd2;
   localparam logic [3:0] A_SUMF    = 4'd3;
   localparam logic [3:0] A_MAGS1   = 4'd4;
   localparam logic [3:0] A_MAGS3   = 4'd5;
   localparam logic [3:0] A_M       = 4'd6;
   localparam logic [3:0] A_M3      = 4'd7;
   localparam logic [3:0] A_DENS    = 4'd8;
   localparam logic [3:0] A_NUM     = 4'd9;
   localparam logic [3:0] A_TMP_SHL = 4'd10;

   localparam logic [2:0] B_MAG   = 3'd0;
   localparam logic [2:0] B_F     = 3'd1;
   localparam logic [2:0] B_DV    = 3'd2;
   localparam logic [2:0] B_M     = 3'd3;
   localparam logic [2:0] B_SUMF  = 3'd4;
   localparam logic [2:0] B_TEMP  = 3'd5;
   localparam logic [2:0] B_MAGS1 = 3'd6;

   localparam logic [1:0] D_M    = 2'd0;
   localparam logic [1:0] D_SUMF = 2'd1;
   localparam logic [1:0] D_DEN  = 2'd2;
   localparam logic [1:0] D_MM   = 2'd3;

   localparam logic [3:0] WB_P2_SET   = 4'd0;
   localparam logic [3:0] WB_P2_ADD   = 4'd1;
   localparam logic [3:0] WB_SUMP2F   = 4'd2;
   localparam logic [3:0] WB_PF       = 4'd3;
   localparam logic [3:0] WB_TMP      = 4'd4;
   localparam logic [3:0] WB_HEAT     = 4'd5;
   localparam logic [3:0] WB_DENS     = 4'd6;
   localparam logic [3:0] WB_FLOW     = 4'd7;
   localparam logic [3:0] WB_SPREAD   = 4'd8;
   localparam logic [3:0] WB_DEN      = 4'd9;
   localparam logic [3:0] WB_TEMP     = 4'd10;
   localparam logic [3:0] WB_PRES     = 4'd11;
   localparam logic [3:0] WB_MM       = 4'd12;
   localparam logic [3:0] WB_HEAT_OUT = 4'd13;

   localparam logic [STEP_WIDTH-1:0] S_SQ0  = 6'd0;
   localparam logic [STEP_WIDTH-1:0] S_SQ1  = 6'd1;
   localparam logic [STEP_WIDTH-1:0] S_SQ2  = 6'd2;
   localparam logic [STEP_WIDTH-1:0] S_P2F  = 6'd3;
   localparam logic [STEP_WIDTH-1:0] S_PF0  = 6'd4;
   localparam logic [STEP_WIDTH-1:0] S_PF1  = 6'd5;
   localparam logic [STEP_WIDTH-1:0] S_PF2  = 6'd6;
   localparam logic [STEP_WIDTH-1:0] S_H0A  = 6'd7;
   localparam logic [STEP_WIDTH-1:0] S_H0B  = 6'd8;
   localparam logic [STEP_WIDTH-1:0] S_H1A  = 6'd9;
   localparam logic [STEP_WIDTH-1:0] S_H1B  = 6'd10;
   localparam logic [STEP_WIDTH-1:0] S_H2A  = 6'd11;
   localparam logic [STEP_WIDTH-1:0] S_H2B  = 6'd12;
   localparam logic [STEP_WIDTH-1:0] S_DENS = 6'd13;
   localparam logic [STEP_WIDTH-1:0] S_FL0A = 6'd14;
   localparam logic [STEP_WIDTH-1:0] S_FL0B = 6'd15;
   localparam logic [STEP_WIDTH-1:0] S_FL1A = 6'd16;
   localparam logic [STEP_WIDTH-1:0] S_FL1B = 6'd17;
   localparam logic [STEP_WIDTH-1:0] S_FL2A = 6'd18;
   localparam logic [STEP_WIDTH-1:0] S_FL2B = 6'd19;
   localparam logic [STEP_WIDTH-1:0] S_SP0A = 6'd20;
   localparam logic [STEP_WIDTH-1:0] S_SP0B = 6'd21;
   localparam logic [STEP_WIDTH-1:0] S_SP1A = 6'd22;
   localparam logic [STEP_WIDTH-1:0] S_SP1B = 6'd23;
   localparam logic [STEP_WIDTH-1:0] S_SP2A = 6'd24;
   localparam logic [STEP_WIDTH-1:0] S_SP2B = 6'd25;
   localparam logic [STEP_WIDTH-1:0] S_DEN  = 6'd26;
   localparam logic [STEP_WIDTH-1:0] S_TEMP = 6'd27;
   localparam logic [STEP_WIDTH-1:0] S_PRES = 6'd28;
   localparam logic [STEP_WIDTH-1:0] S_MM   = 6'd29;
   localparam logic [STEP_WIDTH-1:0] S_HT0A = 6'd30;
   localparam logic [STEP_WIDTH-1:0] S_HT0B = 6'd31;
   localparam logic [STEP_WIDTH-1:0] S_HT1A = 6'd32;
   localparam logic [STEP_WIDTH-1:0] S_HT1B = 6'd33;
   localparam logic [STEP_WIDTH-1:0] S_HT2A = 6'd34;
   localparam logic [STEP_WIDTH-1:0] S_HT2B = 6'd35;

   typedef struct packed {
      logic                  kind;
      logic [3:0]            a_sel;
      logic [2:0]            b_sel;
      logic [1:0]            d_sel;
      logic [3:0]            wb;
      logic [AXIS_WIDTH-1:0] idx;
   } op_type;

   typedef struct packed {
      logic   load;
      logic   start;
      logic   wb_en;
      logic   resp;
      op_type op;
   } cmd_type;

   typedef struct packed {
      logic unit_done;
      logic final_pt;
      logic has_gas;
   } status_type;

   function automatic op_type mk_op(input logic kind, input logic [3:0] a_sel,
                                    input logic [2:0] b_sel, input logic [1:0] d_sel,
                                    input logic [3:0] wb, input logic [AXIS_WIDTH-1:0] idx);
      op_type op;
      op.kind  = kind;
      op.a_sel = a_sel;
      op.b_sel = b_sel;
      op.d_sel = d_sel;
      op.wb    = wb;
      op.idx   = idx;
      return op;
   endfunction

   function automatic op_type step_decode(input logic [STEP_WIDTH-1:0] step);
      op_type op;
      case (step)
         S_SQ0:  op = mk_op(KIND_MUL, A_MAG, B_MAG, D_M, WB_P2_SET, AXIS_X);
         S_SQ1:  op = mk_op(KIND_MUL, A_MAG, B_MAG, D_M, WB_P2_ADD, AXIS_Y);
         S_SQ2:  op = mk_op(KIND_MUL, A_MAG, B_MAG, D_M, WB_P2_ADD, AXIS_Z);
         S_P2F:  op = mk_op(KIND_MUL, A_P2, B_F, D_M, WB_SUMP2F, AXIS_X);
         S_PF0:  op = mk_op(KIND_MUL, A_MAG, B_F, D_M, WB_PF, AXIS_X);
         S_PF1:  op = mk_op(KIND_MUL, A_MAG, B_F, D_M, WB_PF, AXIS_Y);
         S_PF2:  op = mk_op(KIND_MUL, A_MAG, B_F, D_M, WB_PF, AXIS_Z);
         S_H0A:  op = mk_op(KIND_MUL, A_P2, B_MAG, D_M, WB_TMP, AXIS_X);
         S_H0B:  op = mk_op(KIND_MUL, A_TMP, B_F, D_M, WB_HEAT, AXIS_X);
         S_H1A:  op = mk_op(KIND_MUL, A_P2, B_MAG, D_M, WB_TMP, AXIS_Y);
         S_H1B:  op = mk_op(KIND_MUL, A_TMP, B_F, D_M, WB_HEAT, AXIS_Y);
         S_H2A:  op = mk_op(KIND_MUL, A_P2, B_MAG, D_M, WB_TMP, AXIS_Z);
         S_H2B:  op = mk_op(KIND_MUL, A_TMP, B_F, D_M, WB_HEAT, AXIS_Z);
         S_DENS: op = mk_op(KIND_MUL, A_SUMF, B_DV, D_M, WB_DENS, AXIS_X);
         S_FL0A: op = mk_op(KIND_MUL, A_MAGS1, B_DV, D_M, WB_TMP, AXIS_X);
         S_FL0B: op = mk_op(KIND_DIV, A_TMP, B_DV, D_M, WB_FLOW, AXIS_X);
         S_FL1A: op = mk_op(KIND_MUL, A_MAGS1, B_DV, D_M, WB_TMP, AXIS_Y);
         S_FL1B: op = mk_op(KIND_DIV, A_TMP, B_DV, D_M, WB_FLOW, AXIS_Y);
         S_FL2A: op = mk_op(KIND_MUL, A_MAGS1, B_DV, D_M, WB_TMP, AXIS_Z);
         S_FL2B: op = mk_op(KIND_DIV, A_TMP, B_DV, D_M, WB_FLOW, AXIS_Z);
         S_SP0A: op = mk_op(KIND_MUL, A_MAGS1, B_MAGS1, D_M, WB_TMP, AXIS_X);
         S_SP0B: op = mk_op(KIND_DIV, A_TMP, B_F, D_SUMF, WB_SPREAD, AXIS_X);
         S_SP1A: op = mk_op(KIND_MUL, A_MAGS1, B_MAGS1, D_M, WB_TMP, AXIS_Y);
         S_SP1B: op = mk_op(KIND_DIV, A_TMP, B_F, D_SUMF, WB_SPREAD, AXIS_Y);
         S_SP2A: op = mk_op(KIND_MUL, A_MAGS1, B_MAGS1, D_M, WB_TMP, AXIS_Z);
         S_SP2B: op = mk_op(KIND_DIV, A_TMP, B_F, D_SUMF, WB_SPREAD, AXIS_Z);
         S_DEN:  op = mk_op(KIND_MUL, A_M3, B_SUMF, D_M, WB_DEN, AXIS_X);
         S_TEMP: op = mk_op(KIND_DIV, A_NUM, B_F, D_DEN, WB_TEMP, AXIS_X);
         S_PRES: op = mk_op(KIND_MUL, A_DENS, B_TEMP, D_M, WB_PRES, AXIS_X);
         S_MM:   op = mk_op(KIND_MUL, A_M, B_M, D_M, WB_MM, AXIS_X);
         S_HT0A: op = mk_op(KIND_MUL, A_MAGS3, B_DV, D_M, WB_TMP, AXIS_X);
         S_HT0B: op = mk_op(KIND_DIV, A_TMP_SHL, B_F, D_MM, WB_HEAT_OUT, AXIS_X);
         S_HT1A: op = mk_op(KIND_MUL, A_MAGS3, B_DV, D_M, WB_TMP, AXIS_Y);
         S_HT1B: op = mk_op(KIND_DIV, A_TMP_SHL, B_F, D_MM, WB_HEAT_OUT, AXIS_Y);
         S_HT2A: op = mk_op(KIND_MUL, A_MAGS3, B_DV, D_M, WB_TMP, AXIS_Z);
         S_HT2B: op = mk_op(KIND_DIV, A_TMP_SHL, B_F, D_MM, WB_HEAT_OUT, AXIS_Z);
         default: op = mk_op(KIND_MUL, A_MAG, B_MAG, D_M, WB_TMP, AXIS_X);
      endcase
      return op;
   endfunction

endpackage

[sv/velocity_moment_accumulator.sv]
// ----------------------------------------------------------------------------
// velocity_moment_accumulator
// Accumulates moments of a discrete velocity distribution and, on the last
// grid point of a gas, gives density, flow, temperature, pressure and heat.
// ----------------------------------------------------------------------------
// Usage:
//   Drive a grid point on req_* and raise start; it is taken at the edge where
//   start is high and busy is low. busy stays high while the point is worked.
//   Each point is accepted and then runs 13 multiply steps on one serial
//   shift-add multiplier, which stops once no set multiplier bits remain.
//   A point with req_final_point set then runs the evaluation program: up to
//   10 divisions on one restoring divider (which ends at once on a zero
//   divisor) plus 13 serial multiplies and a result state; without gas it
//   stops after flow.
//   The result appears for one cycle with rsp_valid high; the receiver cannot
//   hold it off, and it must take it then. The sums clear in the same cycle.
//   Configuration writes on csr_* are always ready; write only while busy is
//   low. Reset clears all sums and sets both registers to 1.0 (Q16.16).
// ----------------------------------------------------------------------------
module velocity_moment_accumulator (
   input  logic                                        clock,
   input  logic                                        reset,
   input  logic                                        start,
   output logic                                        busy,
   input  logic signed [vma_pkg::IMPULSE_WIDTH-1:0]    req_impulse_x,
   input  logic signed [vma_pkg::IMPULSE_WIDTH-1:0]    req_impulse_y,
   input  logic signed [vma_pkg::IMPULSE_WIDTH-1:0]    req_impulse_z,
   input  logic [vma_pkg::VALUE_WIDTH-1:0]             req_dist_value,
   input  logic                                        req_final_point,
   output logic                                        rsp_valid,
   output logic [vma_pkg::OUT_WIDTH-1:0]               rsp_density,
   output logic signed [vma_pkg::OUT_WIDTH-1:0]        rsp_flow_x,
   output logic signed [vma_pkg::OUT_WIDTH-1:0]        rsp_flow_y,
   output logic signed [vma_pkg::OUT_WIDTH-1:0]        rsp_flow_z,
   output logic [vma_pkg::OUT_WIDTH-1:0]               rsp_gas_temp,
   output logic [vma_pkg::OUT_WIDTH-1:0]               rsp_gas_pressure,
   output logic signed [vma_pkg::OUT_WIDTH-1:0]        rsp_heat_x,
   output logic signed [vma_pkg::OUT_WIDTH-1:0]        rsp_heat_y,
   output logic signed [vma_pkg::OUT_WIDTH-1:0]        rsp_heat_z,
   output logic                                        rsp_has_gas,
   input  logic                                        csr_valid,
   output logic                                        csr_ready,
   input  logic [vma_pkg::CSR_INDEX_WIDTH-1:0]         csr_index,
   input  logic [vma_pkg::CSR_WIDTH-1:0]               csr_wdata
);
   import vma_pkg::*;

   cmd_type    cmd;
   status_type status;

   assign csr_ready = 1'b1;

   vma_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .status    (status),
      .cmd       (cmd)
   );

   vma_dpath u_dpath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .csr_valid        (csr_valid && csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_impulse_x    (req_impulse_x),
      .req_impulse_y    (req_impulse_y),
      .req_impulse_z    (req_impulse_z),
      .req_dist_value   (req_dist_value),
      .req_final_point  (req_final_point),
      .rsp_density      (rsp_density),
      .rsp_flow_x       (rsp_flow_x),
      .rsp_flow_y       (rsp_flow_y),
      .rsp_flow_z       (rsp_flow_z),
      .rsp_gas_temp     (rsp_gas_temp),
      .rsp_gas_pressure (rsp_gas_pressure),
      .rsp_heat_x       (rsp_heat_x),
      .rsp_heat_y       (rsp_heat_y),
      .rsp_heat_z       (rsp_heat_z),
      .rsp_has_gas      (rsp_has_gas)
   );

endmodule

[sv/vma_mul.sv]
// ----------------------------------------------------------------------------
// vma_mul
// Serial shift-add multiplier: one multiplier bit per cycle, stops when the
// remaining multiplier bits are all zero.
// ----------------------------------------------------------------------------
module vma_mul (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            load,
   input  logic [vma_pkg::WIDE_WIDTH-1:0]  a,
   input  logic [vma_pkg::MULB_WIDTH-1:0]  b,
   output logic [vma_pkg::WIDE_WIDTH-1:0]  prod,
   output logic                            done
);
   import vma_pkg::*;

   logic [WIDE_WIDTH-1:0] a_ff, a_in, prod_ff, prod_in;
   logic [MULB_WIDTH-1:0] b_ff, b_in;

   always_comb begin
      a_in    = a_ff;
      b_in    = b_ff;
      prod_in = prod_ff;
      if (load) begin
         a_in    = a;
         b_in    = b;
         prod_in = '0;
      end else if (b_ff != '0) begin
         if (b_ff[0]) begin
            prod_in = prod_ff + a_ff;
         end
         a_in = a_ff << 1;
         b_in = b_ff >> 1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_ff <= '0;
      end else begin
         b_ff <= b_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff    <= a_in;
      prod_ff <= prod_in;
   end

   assign prod = prod_ff;
   assign done = (b_ff == '0);

endmodule

[sv/vma_div.sv]
// ----------------------------------------------------------------------------
// vma_div
// Restoring divider, one quotient bit per cycle. A zero divisor gives an
// all-ones quotient at once.
// ----------------------------------------------------------------------------
module vma_div (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            load,
   input  logic [vma_pkg::WIDE_WIDTH-1:0]  num,
   input  logic [vma_pkg::WIDE_WIDTH-1:0]  den,
   output logic [vma_pkg::WIDE_WIDTH-1:0]  quot,
   output logic                            done
);
   import vma_pkg::*;

   logic [WIDE_WIDTH-1:0] r_ff, r_in, q_ff, q_in, d_ff, d_in;
   logic [CNT_WIDTH-1:0]  cnt_ff, cnt_in;

   always_comb begin
      logic [WIDE_WIDTH:0] rr;
      logic [WIDE_WIDTH:0] diff;
      rr     = {r_ff, q_ff[WIDE_WIDTH-1]};
      diff   = rr - {1'b0, d_ff};
      r_in   = r_ff;
      q_in   = q_ff;
      d_in   = d_ff;
      cnt_in = cnt_ff;
      if (load) begin
         r_in = '0;
         d_in = den;
         if (den == '0) begin
            q_in   = '1;
            cnt_in = '0;
         end else begin
            q_in   = num;
            cnt_in = CNT_WIDTH'(WIDE_WIDTH);
         end
      end else if (cnt_ff != '0) begin
         if (rr >= {1'b0, d_ff}) begin
            r_in = diff[WIDE_WIDTH-1:0];
            q_in = {q_ff[WIDE_WIDTH-2:0], 1'b1};
         end else begin
            r_in = rr[WIDE_WIDTH-1:0];
            q_in = {q_ff[WIDE_WIDTH-2:0], 1'b0};
         end
         cnt_in = cnt_ff - CNT_WIDTH'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      r_ff <= r_in;
      q_ff <= q_in;
      d_ff <= d_in;
   end

   assign quot = q_ff;
   assign done = (cnt_ff == '0);

endmodule

[sv/vma_ctrl.sv]
// ----------------------------------------------------------------------------
// vma_ctrl
// Step sequencer: walks the per-point program and, on the last point, the
// moment evaluation program, one multiply or divide per step.
// ----------------------------------------------------------------------------
module vma_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   output logic                 rsp_valid,
   input  vma_pkg::status_type  status,
   output vma_pkg::cmd_type     cmd
);
   import vma_pkg::*;

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_ISSUE = 2'd1;
   localparam logic [1:0] ST_WAIT  = 2'd2;
   localparam logic [1:0] ST_RESP  = 2'd3;

   logic [1:0]            state_ff, state_in;
   logic [STEP_WIDTH-1:0] step_ff, step_in;

   always_comb begin
      state_in  = state_ff;
      step_in   = step_ff;
      cmd.load  = 1'b0;
      cmd.start = 1'b0;
      cmd.wb_en = 1'b0;
      cmd.resp  = 1'b0;
      cmd.op    = step_decode(step_ff);
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               step_in  = S_SQ0;
               state_in = ST_ISSUE;
            end
         end
         ST_ISSUE: begin
            cmd.start = 1'b1;
            state_in  = ST_WAIT;
         end
         ST_WAIT: begin
            if (status.unit_done) begin
               cmd.wb_en = 1'b1;
               state_in  = ST_ISSUE;
               if (step_ff == S_H2B) begin
                  step_in = S_DENS;
                  if (!status.final_pt) begin
                     state_in = ST_IDLE;
                  end
               end else if (step_ff == S_FL2B && !status.has_gas) begin
                  state_in = ST_RESP;
               end else if (step_ff == S_HT2B) begin
                  state_in = ST_RESP;
               end else begin
                  step_in = step_ff + STEP_WIDTH'(1);
               end
            end
         end
         ST_RESP: begin
            cmd.resp = 1'b1;
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= S_SQ0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = (state_ff == ST_RESP);

   a_resp_after_wait: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_RESP |-> $past(state_ff) == ST_WAIT)
      else $error("response without a finished step");

   a_issue_then_wait: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_ISSUE |=> state_ff == ST_WAIT)
      else $error("issue not followed by wait");

   a_step_in_range: assert property (@(posedge clock) disable iff (reset)
      state_ff != ST_IDLE |-> step_ff <= S_HT2B)
      else $error("step out of program");

   a_load_only_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> !busy && !cmd.wb_en)
      else $error("load while busy");

endmodule

[sv/vma_dpath.sv]
// ----------------------------------------------------------------------------
// vma_dpath
// Datapath: configuration registers, running moment sums, operand selection
// for the shared multiplier and divider, write-back and result registers.
// ----------------------------------------------------------------------------
module vma_dpath (
   input  logic                                        clock,
   input  logic                                        reset,
   input  vma_pkg::cmd_type                            cmd,
   output vma_pkg::status_type                         status,
   input  logic                                        csr_valid,
   input  logic [vma_pkg::CSR_INDEX_WIDTH-1:0]         csr_index,
   input  logic [vma_pkg::CSR_WIDTH-1:0]               csr_wdata,
   input  logic signed [vma_pkg::IMPULSE_WIDTH-1:0]    req_impulse_x,
   input  logic signed [vma_pkg::IMPULSE_WIDTH-1:0]    req_impulse_y,
   input  logic signed [vma_pkg::IMPULSE_WIDTH-1:0]    req_impulse_z,
   input  logic [vma_pkg::VALUE_WIDTH-1:0]             req_dist_value,
   input  logic                                        req_final_point,
   output logic [vma_pkg::OUT_WIDTH-1:0]               rsp_density,
   output logic signed [vma_pkg::OUT_WIDTH-1:0]        rsp_flow_x,
   output logic signed [vma_pkg::OUT_WIDTH-1:0]        rsp_flow_y,
   output logic signed [vma_pkg::OUT_WIDTH-1:0]        rsp_flow_z,
   output logic [vma_pkg::OUT_WIDTH-1:0]               rsp_gas_temp,
   output logic [vma_pkg::OUT_WIDTH-1:0]               rsp_gas_pressure,
   output logic signed [vma_pkg::OUT_WIDTH-1:0]        rsp_heat_x,
   output logic signed [vma_pkg::OUT_WIDTH-1:0]        rsp_heat_y,
   output logic signed [vma_pkg::OUT_WIDTH-1:0]        rsp_heat_z,
   output logic                                        rsp_has_gas
);
   import vma_pkg::*;

   function automatic logic [ACC_WIDTH-1:0] add_u(input logic [ACC_WIDTH-1:0] a,
                                                 input logic [ACC_WIDTH-1:0] t);
      logic [ACC_WIDTH:0] s;
      s = {1'b0, a} + {1'b0, t};
      return s[ACC_WIDTH] ? '1 : s[ACC_WIDTH-1:0];
   endfunction

   function automatic logic signed [ACC_WIDTH-1:0] add_s(input logic signed [ACC_WIDTH-1:0] a,
                                                        input logic signed [ACC_WIDTH-1:0] t);
      logic [ACC_WIDTH:0] s;
      s = {a[ACC_WIDTH-1], a} + {t[ACC_WIDTH-1], t};
      if (s[ACC_WIDTH] != s[ACC_WIDTH-1]) begin
         return s[ACC_WIDTH] ? {1'b1, {(ACC_WIDTH-1){1'b0}}} : {1'b0, {(ACC_WIDTH-1){1'b1}}};
      end
      return s[ACC_WIDTH-1:0];
   endfunction

   function automatic logic signed [ACC_WIDTH-1:0] sat_acc_s(input logic [WIDE_WIDTH-1:0] mag,
                                                            input logic neg);
      logic [WIDE_WIDTH-1:0] lim;
      logic [WIDE_WIDTH-1:0] m;
      lim = neg ? (WIDE_WIDTH'(1) << (ACC_WIDTH-1))
                : ((WIDE_WIDTH'(1) << (ACC_WIDTH-1)) - WIDE_WIDTH'(1));
      m   = (mag > lim) ? lim : mag;
      return neg ? (~m[ACC_WIDTH-1:0] + ACC_WIDTH'(1)) : m[ACC_WIDTH-1:0];
   endfunction

   function automatic logic [OUT_WIDTH-1:0] out_s(input logic [WIDE_WIDTH-1:0] mag,
                                                 input logic neg);
      logic [WIDE_WIDTH-1:0] lim;
      logic [WIDE_WIDTH-1:0] m;
      lim = neg ? (WIDE_WIDTH'(1) << (OUT_WIDTH-1))
                : ((WIDE_WIDTH'(1) << (OUT_WIDTH-1)) - WIDE_WIDTH'(1));
      m   = (mag > lim) ? lim : mag;
      return neg ? (~m[OUT_WIDTH-1:0] + OUT_WIDTH'(1)) : m[OUT_WIDTH-1:0];
   endfunction

   function automatic logic [OUT_WIDTH-1:0] sat_out(input logic [WIDE_WIDTH-1:0] x);
      return (x[WIDE_WIDTH-1:OUT_WIDTH] != '0) ? '1 : x[OUT_WIDTH-1:0];
   endfunction

   function automatic logic [ACC_WIDTH-1:0] mag_of(input logic signed [ACC_WIDTH-1:0] s);
      return s[ACC_WIDTH-1] ? (~s + ACC_WIDTH'(1)) : s;
   endfunction

   logic [CSR_WIDTH-1:0]         m_ff, m_in, dv_ff, dv_in;
   logic [IMPULSE_WIDTH-1:0]     mag_ff [NUM_AXES];
   logic [IMPULSE_WIDTH-1:0]     mag_in [NUM_AXES];
   logic                         neg_ff [NUM_AXES];
   logic                         neg_in [NUM_AXES];
   logic [VALUE_WIDTH-1:0]       f_ff, f_in;
   logic                         final_ff, final_in;
   logic [ACC_WIDTH-1:0]         sum_f_ff, sum_f_in, sum_p2f_ff, sum_p2f_in;
   logic signed [ACC_WIDTH-1:0]  pf_ff [NUM_AXES];
   logic signed [ACC_WIDTH-1:0]  pf_in [NUM_AXES];
   logic signed [ACC_WIDTH-1:0]  ht_ff [NUM_AXES];
   logic signed [ACC_WIDTH-1:0]  ht_in [NUM_AXES];
   logic [P2_WIDTH-1:0]          p2_ff, p2_in;
   logic [WIDE_WIDTH-1:0]        tmp_ff, tmp_in, den_ff, den_in, spread_ff, spread_in;
   logic [2*CSR_WIDTH-1:0]       mm_ff, mm_in;
   logic [OUT_WIDTH-1:0]         dens_ff, dens_in, temp_ff, temp_in, pres_ff, pres_in;
   logic [OUT_WIDTH-1:0]         flow_ff [NUM_AXES];
   logic [OUT_WIDTH-1:0]         flow_in [NUM_AXES];
   logic [OUT_WIDTH-1:0]         hout_ff [NUM_AXES];
   logic [OUT_WIDTH-1:0]         hout_in [NUM_AXES];

   logic [IMPULSE_WIDTH-1:0]     mag_sel;
   logic                         neg_sel;
   logic signed [ACC_WIDTH-1:0]  pf_sel, ht_sel;
   logic [ACC_WIDTH-1:0]         mags1, mags3, n_val;
   logic [CSR_WIDTH+1:0]         m3;
   logic [WIDE_WIDTH-1:0]        a_mux, d_mux, prod, quot, spread_sum;
   logic [MULB_WIDTH-1:0]        b_mux;
   logic                         mul_done, div_done, has_gas;
   logic [IMPULSE_WIDTH-1:0]     raw [NUM_AXES];

   always_comb begin
      case (cmd.op.idx)
         AXIS_Y: begin
            mag_sel = mag_ff[1];
            neg_sel = neg_ff[1];
            pf_sel  = pf_ff[1];
            ht_sel  = ht_ff[1];
         end
         AXIS_Z: begin
            mag_sel = mag_ff[2];
            neg_sel = neg_ff[2];
            pf_sel  = pf_ff[2];
            ht_sel  = ht_ff[2];
         end
         default: begin
            mag_sel = mag_ff[0];
            neg_sel = neg_ff[0];
            pf_sel  = pf_ff[0];
            ht_sel  = ht_ff[0];
         end
      endcase
   end

   assign mags1   = mag_of(pf_sel);
   assign mags3   = mag_of(ht_sel);
   assign m3      = {1'b0, m_ff, 1'b0} + {2'b00, m_ff};
   assign n_val   = (spread_ff < WIDE_WIDTH'(sum_p2f_ff))
                    ? (sum_p2f_ff - spread_ff[ACC_WIDTH-1:0]) : '0;
   assign has_gas = (dens_ff != '0);

   always_comb begin
      case (cmd.op.a_sel)
         A_MAG:     a_mux = WIDE_WIDTH'(mag_sel);
         A_P2:      a_mux = WIDE_WIDTH'(p2_ff);
         A_TMP:     a_mux = tmp_ff;
         A_SUMF:    a_mux = WIDE_WIDTH'(sum_f_ff);
         A_MAGS1:   a_mux = WIDE_WIDTH'(mags1);
         A_MAGS3:   a_mux = WIDE_WIDTH'(mags3);
         A_M:       a_mux = WIDE_WIDTH'(m_ff);
         A_M3:      a_mux = WIDE_WIDTH'(m3);
         A_DENS:    a_mux = WIDE_WIDTH'(dens_ff);
         A_NUM:     a_mux = WIDE_WIDTH'(n_val) << TEMP_SHIFT;
         A_TMP_SHL: a_mux = tmp_ff << FLUX_SHIFT;
         default:   a_mux = '0;
      endcase
   end

   always_comb begin
      case (cmd.op.b_sel)
         B_MAG:   b_mux = MULB_WIDTH'(mag_sel);
         B_F:     b_mux = MULB_WIDTH'(f_ff);
         B_DV:    b_mux = MULB_WIDTH'(dv_ff);
         B_M:     b_mux = MULB_WIDTH'(m_ff);
         B_SUMF:  b_mux = MULB_WIDTH'(sum_f_ff);
         B_TEMP:  b_mux = MULB_WIDTH'(temp_ff);
         B_MAGS1: b_mux = MULB_WIDTH'(mags1);
         default: b_mux = '0;
      endcase
   end

   always_comb begin
      case (cmd.op.d_sel)
         D_M:     d_mux = WIDE_WIDTH'(m_ff);
         D_SUMF:  d_mux = WIDE_WIDTH'(sum_f_ff);
         D_DEN:   d_mux = den_ff;
         D_MM:    d_mux = WIDE_WIDTH'(mm_ff);
         default: d_mux = '0;
      endcase
   end

   vma_mul u_mul (
      .clock (clock),
      .reset (reset),
      .load  (cmd.start && cmd.op.kind == KIND_MUL),
      .a     (a_mux),
      .b     (b_mux),
      .prod  (prod),
      .done  (mul_done)
   );

   vma_div u_div (
      .clock (clock),
      .reset (reset),
      .load  (cmd.start && cmd.op.kind == KIND_DIV),
      .num   (a_mux),
      .den   (d_mux),
      .quot  (quot),
      .done  (div_done)
   );

   always_comb begin
      logic [WIDE_WIDTH:0] ssum;
      ssum       = {1'b0, spread_ff} + {1'b0, quot};
      spread_sum = ssum[WIDE_WIDTH] ? '1 : ssum[WIDE_WIDTH-1:0];
   end

   assign raw[0] = req_impulse_x;
   assign raw[1] = req_impulse_y;
   assign raw[2] = req_impulse_z;

   always_comb begin
      m_in       = m_ff;
      dv_in      = dv_ff;
      f_in       = f_ff;
      final_in   = final_ff;
      sum_f_in   = sum_f_ff;
      sum_p2f_in = sum_p2f_ff;
      p2_in      = p2_ff;
      tmp_in     = tmp_ff;
      den_in     = den_ff;
      spread_in  = spread_ff;
      mm_in      = mm_ff;
      dens_in    = dens_ff;
      temp_in    = temp_ff;
      pres_in    = pres_ff;
      for (int k = 0; k < NUM_AXES; k++) begin
         mag_in[k]  = mag_ff[k];
         neg_in[k]  = neg_ff[k];
         pf_in[k]   = pf_ff[k];
         ht_in[k]   = ht_ff[k];
         flow_in[k] = flow_ff[k];
         hout_in[k] = hout_ff[k];
      end

      if (csr_valid) begin
         if (csr_index == CSR_PARTICLE_MASS) begin
            m_in = csr_wdata;
         end else begin
            dv_in = csr_wdata;
         end
      end

      if (cmd.load) begin
         for (int k = 0; k < NUM_AXES; k++) begin
            neg_in[k] = raw[k][IMPULSE_WIDTH-1];
            mag_in[k] = raw[k][IMPULSE_WIDTH-1] ? (~raw[k] + IMPULSE_WIDTH'(1)) : raw[k];
         end
         f_in     = req_dist_value;
         final_in = req_final_point;
         sum_f_in = add_u(sum_f_ff, ACC_WIDTH'(req_dist_value));
      end

      if (cmd.wb_en) begin
         case (cmd.op.wb)
            WB_P2_SET: p2_in = prod[P2_WIDTH-1:0];
            WB_P2_ADD: p2_in = p2_ff + prod[P2_WIDTH-1:0];
            WB_SUMP2F: begin
               sum_p2f_in = add_u(sum_p2f_ff,
                  (prod[WIDE_WIDTH-1:ACC_WIDTH+P2F_SHIFT] != '0)
                  ? '1 : prod[ACC_WIDTH+P2F_SHIFT-1:P2F_SHIFT]);
            end
            WB_PF: begin
               for (int k = 0; k < NUM_AXES; k++) begin
                  if (AXIS_WIDTH'(k) == cmd.op.idx) begin
                     pf_in[k] = add_s(pf_ff[k], sat_acc_s(prod >> PF_SHIFT, neg_sel));
                  end
               end
            end
            WB_TMP:    tmp_in = prod;
            WB_HEAT: begin
               for (int k = 0; k < NUM_AXES; k++) begin
                  if (AXIS_WIDTH'(k) == cmd.op.idx) begin
                     ht_in[k] = add_s(ht_ff[k], sat_acc_s(prod >> HEAT_SHIFT, neg_sel));
                  end
               end
            end
            WB_DENS:   dens_in = sat_out(prod >> DENS_SHIFT);
            WB_FLOW: begin
               for (int k = 0; k < NUM_AXES; k++) begin
                  if (AXIS_WIDTH'(k) == cmd.op.idx) begin
                     flow_in[k] = out_s(quot, pf_sel[ACC_WIDTH-1]);
                  end
               end
            end
            WB_SPREAD: spread_in = (cmd.op.idx == AXIS_X) ? quot : spread_sum;
            WB_DEN:    den_in = prod;
            WB_TEMP:   temp_in = sat_out(quot);
            WB_PRES:   pres_in = sat_out(prod >> DENS_SHIFT);
            WB_MM:     mm_in = prod[2*CSR_WIDTH-1:0];
            WB_HEAT_OUT: begin
               for (int k = 0; k < NUM_AXES; k++) begin
                  if (AXIS_WIDTH'(k) == cmd.op.idx) begin
                     hout_in[k] = out_s(quot, ht_sel[ACC_WIDTH-1]);
                  end
               end
            end
            default: begin
               tmp_in = tmp_ff;
            end
         endcase
      end

      if (cmd.resp) begin
         sum_f_in   = '0;
         sum_p2f_in = '0;
         for (int k = 0; k < NUM_AXES; k++) begin
            pf_in[k] = '0;
            ht_in[k] = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m_ff       <= CSR_RESET_VALUE;
         dv_ff      <= CSR_RESET_VALUE;
         sum_f_ff   <= '0;
         sum_p2f_ff <= '0;
         for (int k = 0; k < NUM_AXES; k++) begin
            pf_ff[k] <= '0;
            ht_ff[k] <= '0;
         end
      end else begin
         m_ff       <= m_in;
         dv_ff      <= dv_in;
         sum_f_ff   <= sum_f_in;
         sum_p2f_ff <= sum_p2f_in;
         for (int k = 0; k < NUM_AXES; k++) begin
            pf_ff[k] <= pf_in[k];
            ht_ff[k] <= ht_in[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      f_ff      <= f_in;
      final_ff  <= final_in;
      p2_ff     <= p2_in;
      tmp_ff    <= tmp_in;
      den_ff    <= den_in;
      spread_ff <= spread_in;
      mm_ff     <= mm_in;
      dens_ff   <= dens_in;
      temp_ff   <= temp_in;
      pres_ff   <= pres_in;
      for (int k = 0; k < NUM_AXES; k++) begin
         mag_ff[k]  <= mag_in[k];
         neg_ff[k]  <= neg_in[k];
         flow_ff[k] <= flow_in[k];
         hout_ff[k] <= hout_in[k];
      end
   end

   assign status.unit_done = (cmd.op.kind == KIND_DIV) ? div_done : mul_done;
   assign status.final_pt  = final_ff;
   assign status.has_gas   = has_gas;

   assign rsp_density      = dens_ff;
   assign rsp_flow_x       = flow_ff[0];
   assign rsp_flow_y       = flow_ff[1];
   assign rsp_flow_z       = flow_ff[2];
   assign rsp_gas_temp     = has_gas ? temp_ff : '0;
   assign rsp_gas_pressure = has_gas ? pres_ff : '0;
   assign rsp_heat_x       = has_gas ? hout_ff[0] : '0;
   assign rsp_heat_y       = has_gas ? hout_ff[1] : '0;
   assign rsp_heat_z       = has_gas ? hout_ff[2] : '0;
   assign rsp_has_gas      = has_gas;

endmodule

[tb/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for velocity_moment_accumulator: streams grid points
// under random start gaps, predicts every gas result with a bit-exact model
// of the moment sums, and compares each result strobe against it. Register
// settings change between phases while the block is idle.
// ----------------------------------------------------------------------------
module tb;
   import vma_pkg::*;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int SETTLE_CYCLES  = 3000;
   localparam logic [127:0] MAX48 = (128'd1 << 48) - 1;
   localparam logic [127:0] MAX64 = (128'd1 << 64) - 1;

   typedef struct {
      logic signed [IMPULSE_WIDTH-1:0] px, py, pz;
      logic [VALUE_WIDTH-1:0]          f;
      logic                            fin;
   } point_t;

   typedef struct {
      logic [OUT_WIDTH-1:0] density, temp, pressure;
      logic [OUT_WIDTH-1:0] flow [3];
      logic [OUT_WIDTH-1:0] heat [3];
      logic                 has_gas;
   } moments_t;

   logic clock, reset, start, busy;
   logic signed [IMPULSE_WIDTH-1:0] req_impulse_x, req_impulse_y, req_impulse_z;
   logic [VALUE_WIDTH-1:0] req_dist_value;
   logic req_final_point;
   logic rsp_valid, rsp_has_gas;
   logic [OUT_WIDTH-1:0] rsp_density, rsp_gas_temp, rsp_gas_pressure;
   logic signed [OUT_WIDTH-1:0] rsp_flow_x, rsp_flow_y, rsp_flow_z;
   logic signed [OUT_WIDTH-1:0] rsp_heat_x, rsp_heat_y, rsp_heat_z;
   logic csr_valid, csr_ready;
   logic [CSR_INDEX_WIDTH-1:0] csr_index;
   logic [CSR_WIDTH-1:0] csr_wdata;

   velocity_moment_accumulator uut (.*);

   point_t   pending_points[$];
   point_t   held_point;
   moments_t expected_moments[$];
   int       errors = 0;
   int       gap_left = 0;
   logic     no_idle = 0;
   int       quiet_cycles = 0;

   // predictor state
   logic [63:0] mass_reg, volume_reg;
   logic [63:0] sum_f, sum_p2f;
   logic signed [63:0] sum_pf [3];
   logic signed [63:0] sum_ht [3];

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   function automatic logic [127:0] udiv(input logic [127:0] a, input logic [127:0] b);
      return (b == 0) ? ~128'd0 : a / b;
   endfunction

   function automatic logic [127:0] clamp_u(input logic [127:0] x, input logic [127:0] mx);
      return (x > mx) ? mx : x;
   endfunction

   function automatic logic [63:0] signed_term(input logic [127:0] mg, input logic neg);
      logic [127:0] lim;
      logic [63:0]  m;
      lim = neg ? (128'd1 << 63) : (128'd1 << 63) - 1;
      m = (mg > lim) ? lim[63:0] : mg[63:0];
      return neg ? -m : m;
   endfunction

   function automatic logic [47:0] signed_out(input logic [127:0] mg, input logic neg);
      logic [127:0] lim;
      logic [47:0]  m;
      lim = neg ? (128'd1 << 47) : (128'd1 << 47) - 1;
      m = (mg > lim) ? lim[47:0] : mg[47:0];
      return neg ? -m : m;
   endfunction

   function automatic logic signed [63:0] add_signed(input logic signed [63:0] a,
                                                     input logic signed [63:0] t);
      logic signed [64:0] s;
      s = 65'(a) + 65'(t);
      if (s > 65'sh0_7fff_ffff_ffff_ffff) return 64'sh7fff_ffff_ffff_ffff;
      if (s < -65'sh0_8000_0000_0000_0000) return 64'sh8000_0000_0000_0000;
      return s[63:0];
   endfunction

   function automatic logic [63:0] abs64(input logic signed [63:0] a);
      return a[63] ? -a : a;
   endfunction

   task automatic absorb_point(input point_t pt);
      logic [15:0]  mg [3];
      logic         ng [3];
      logic [15:0]  raw [3];
      logic [127:0] p2, w, spread, n, m, dv, a;
      logic [128:0] acc;
      logic [127:0] dens, temp, pres;
      moments_t     r;
      raw[0] = pt.px; raw[1] = pt.py; raw[2] = pt.pz;
      p2 = 0;
      for (int i = 0; i < 3; i++) begin
         ng[i] = raw[i][15];
         mg[i] = ng[i] ? -raw[i] : raw[i];
         p2 += 128'(mg[i]) * 128'(mg[i]);
      end
      w = 128'(sum_f) + 128'(pt.f);
      sum_f = clamp_u(w, MAX64);
      w = clamp_u((p2 * 128'(pt.f)) >> 16, MAX64);
      sum_p2f = clamp_u(128'(sum_p2f) + w, MAX64);
      for (int i = 0; i < 3; i++) begin
         sum_pf[i] = add_signed(sum_pf[i], signed_term((128'(mg[i]) * pt.f) >> 8, ng[i]));
         sum_ht[i] = add_signed(sum_ht[i],
                                signed_term((128'(mg[i]) * p2 * pt.f) >> 24, ng[i]));
      end
      if (!pt.fin) return;
      m = 128'(mass_reg); dv = 128'(volume_reg);
      dens = clamp_u((128'(sum_f) * dv) >> 16, MAX48);
      r.density = dens[47:0];
      for (int i = 0; i < 3; i++)
         r.flow[i] = signed_out(udiv(128'(abs64(sum_pf[i])) * dv, m), sum_pf[i][63]);
      if (dens != 0) begin
         spread = 0;
         for (int i = 0; i < 3; i++) begin
            a = 128'(abs64(sum_pf[i]));
            acc = 129'(spread) + 129'(udiv(a * a, 128'(sum_f)));
            spread = acc[128] ? ~128'd0 : acc[127:0];
         end
         n = (spread < 128'(sum_p2f)) ? 128'(sum_p2f) - spread : 128'd0;
         temp = clamp_u(udiv(n << 32, (m * 3) * 128'(sum_f)), MAX48);
         r.temp = temp[47:0];
         pres = clamp_u((dens * temp) >> 16, MAX48);
         r.pressure = pres[47:0];
         for (int i = 0; i < 3; i++)
            r.heat[i] = signed_out(udiv((128'(abs64(sum_ht[i])) * dv) << 15, m * m),
                                   sum_ht[i][63]);
         r.has_gas = 1;
      end else begin
         r.temp = 0; r.pressure = 0; r.has_gas = 0;
         for (int i = 0; i < 3; i++) r.heat[i] = 0;
      end
      expected_moments.push_back(r);
      sum_f = 0; sum_p2f = 0;
      for (int i = 0; i < 3; i++) begin
         sum_pf[i] = 0; sum_ht[i] = 0;
      end
   endtask

   function automatic int pick_gap();
      int r;
      if (no_idle) return 0;
      r = $urandom_range(99);
      if (r < 65) return 0;
      if (r < 95) return $urandom_range(1, 4);
      return $urandom_range(20, 200);
   endfunction

   // driver
   always @(posedge clock) begin
      if (reset) begin
         start <= 0;
         gap_left <= 0;
      end else if (!(start && busy)) begin
         if (start) absorb_point(held_point);
         if (gap_left > 0) begin
            gap_left <= gap_left - 1;
            start <= 0;
         end else if (pending_points.size() > 0) begin
            held_point = pending_points.pop_front();
            req_impulse_x <= held_point.px;
            req_impulse_y <= held_point.py;
            req_impulse_z <= held_point.pz;
            req_dist_value <= held_point.f;
            req_final_point <= held_point.fin;
            start <= 1;
            gap_left <= pick_gap();
         end else begin
            start <= 0;
         end
      end
   end

   task automatic check_field(input string name, input logic [47:0] exp_v,
                              input logic [47:0] act_v);
      if (exp_v !== act_v) begin
         $error("%s: expected %h, actual %h", name, exp_v, act_v);
         errors++;
      end
   endtask

   // monitor
   always @(posedge clock) begin
      moments_t e;
      if (!reset && rsp_valid) begin
         if (expected_moments.size() == 0) begin
            $error("result with no request pending");
            errors++;
         end else begin
            e = expected_moments.pop_front();
            check_field("density", e.density, rsp_density);
            check_field("flow_x", e.flow[0], rsp_flow_x);
            check_field("flow_y", e.flow[1], rsp_flow_y);
            check_field("flow_z", e.flow[2], rsp_flow_z);
            check_field("gas_temp", e.temp, rsp_gas_temp);
            check_field("gas_pressure", e.pressure, rsp_gas_pressure);
            check_field("heat_x", e.heat[0], rsp_heat_x);
            check_field("heat_y", e.heat[1], rsp_heat_y);
            check_field("heat_z", e.heat[2], rsp_heat_z);
            check_field("has_gas", 48'(e.has_gas), 48'(rsp_has_gas));
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   task automatic write_reg(input logic [CSR_INDEX_WIDTH-1:0] idx, input logic [31:0] val);
      @(posedge clock);
      csr_index <= idx;
      csr_wdata <= val;
      csr_valid <= 1;
      do @(posedge clock); while (!csr_ready);
      if (idx == CSR_PARTICLE_MASS) mass_reg = 64'(val);
      else volume_reg = 64'(val);
      csr_valid <= 0;
   endtask

   task automatic settle();
      wait (pending_points.size() == 0 && !start);
      wait (expected_moments.size() == 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic point_t mk_point(input logic [15:0] x, input logic [15:0] y,
                                       input logic [15:0] z, input logic [31:0] f,
                                       input logic fin);
      point_t p;
      p.px = x; p.py = y; p.pz = z; p.f = f; p.fin = fin;
      return p;
   endfunction

   function automatic logic [15:0] rand_impulse();
      case ($urandom_range(3))
         0: return 16'($urandom_range(0, 255) - 128);
         1: return 16'($urandom_range(0, 8191) - 4096);
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [31:0] rand_value();
      case ($urandom_range(9))
         0: return 0;
         1, 2: return $urandom_range(0, 65535);
         3: return 32'hffff_ffff;
         4, 5: return $urandom_range(0, 24'hff_ffff);
         default: return $urandom;
      endcase
   endfunction

   task automatic queue_phase(input int count);
      int n, len;
      n = 0;
      while (n < count) begin
         if ($urandom_range(9) == 0) begin
            pending_points.push_back(mk_point(rand_impulse(), rand_impulse(), rand_impulse(),
                                              rand_value(), 1'($urandom_range(1))));
            n++;
         end else begin
            len = ($urandom_range(9) == 0) ? $urandom_range(15, 30) : $urandom_range(1, 8);
            for (int k = 0; k < len; k++)
               pending_points.push_back(mk_point(rand_impulse(), rand_impulse(),
                                                 rand_impulse(), rand_value(), k == len - 1));
            n += len;
         end
      end
   endtask

   logic [31:0] mass_set [6] = '{32'd1, 32'hffff_ffff, 32'd0, 32'd65536, 32'd3, 32'd0};
   logic [31:0] vol_set  [6] = '{32'd1, 32'hffff_ffff, 32'd65536, 32'd0, 32'd0, 32'd0};

   initial begin
      reset = 1;
      start = 0;
      req_impulse_x = 0; req_impulse_y = 0; req_impulse_z = 0;
      req_dist_value = 0; req_final_point = 0;
      csr_valid = 0; csr_index = CSR_PARTICLE_MASS; csr_wdata = 0;
      mass_reg = 64'(CSR_RESET_VALUE); volume_reg = 64'(CSR_RESET_VALUE);
      sum_f = 0; sum_p2f = 0;
      for (int i = 0; i < 3; i++) begin
         sum_pf[i] = 0; sum_ht[i] = 0;
      end
      repeat (4) @(posedge clock);
      reset <= 0;

      pending_points.push_back(mk_point(16'sh7fff, 16'sh7fff, 16'sh7fff, 32'hffff_ffff, 0));
      pending_points.push_back(mk_point(16'sh8000, 16'sh8000, 16'sh8000, 32'hffff_ffff, 1));
      pending_points.push_back(mk_point(16'sh8000, 16'sh7fff, 16'sh0000, 32'hffff_ffff, 1));
      pending_points.push_back(mk_point(16'sh1234, 16'shedcb, 16'sh0001, 32'd0, 1));
      pending_points.push_back(mk_point(16'sh0000, 16'sh0000, 16'sh0000, 32'd1, 1));
      pending_points.push_back(mk_point(16'sh0001, 16'sh0001, 16'sh0001, 32'd65536, 0));
      pending_points.push_back(mk_point(16'shffff, 16'shffff, 16'shffff, 32'd65536, 1));
      pending_points.push_back(mk_point(16'sh0100, 16'sh0000, 16'sh0000, 32'd65536, 0));
      pending_points.push_back(mk_point(16'sh0100, 16'sh0000, 16'sh0000, 32'd65536, 1));
      pending_points.push_back(mk_point(16'sh5555, 16'shaaaa, 16'sh5555, 32'h5555_5555, 0));
      pending_points.push_back(mk_point(16'shaaaa, 16'sh5555, 16'shaaaa, 32'haaaa_aaaa, 1));
      pending_points.push_back(mk_point(16'sh0001, 16'sh0000, 16'sh0000, 32'd65536, 1));
      queue_phase(60);
      settle();

      for (int ph = 0; ph < 6; ph++) begin
         write_reg(CSR_PARTICLE_MASS, mass_set[ph]);
         write_reg(CSR_CELL_VOLUME, vol_set[ph]);
         no_idle = (ph % 3 == 1);
         queue_phase(55);
         settle();
      end
      write_reg(CSR_CELL_VOLUME, $urandom);
      write_reg(CSR_PARTICLE_MASS, $urandom_range(1, 32'h0010_0000));
      queue_phase(60);
      settle();

      if (errors == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end
endmodule
